@@ design/framebuffer_text_renderer_core_macros.svh @@
// assertion macros for the text renderer core
`ifndef FRAMEBUFFER_TEXT_RENDERER_CORE_MACROS_SVH
`define FRAMEBUFFER_TEXT_RENDERER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define FBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define FBT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/fbt_pkg.sv @@
// types, constants and glyph tables for the text renderer
package fbt_pkg;

  localparam logic [1:0] ACT_CLEAR      = 2'd0;
  localparam logic [1:0] ACT_DRAW_CHAR  = 2'd1;
  localparam logic [1:0] ACT_DRAW_VALUE = 2'd2;
  localparam logic [1:0] ACT_READ_BYTE  = 2'd3;

  localparam logic [7:0] LABEL_X    = 8'd37;
  localparam logic [7:0] LABEL_Y    = 8'd5;
  localparam logic [7:0] VALUE_Y    = 8'd28;
  localparam logic [3:0] LABEL_LEN  = 4'd9;
  localparam logic [5:0] DIGIT_W    = 6'd12;
  localparam logic [7:0] PITCH      = 8'd6;
  localparam logic [7:0] CODE_ZERO  = 8'h30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DABBLE,
    ST_TEXT,
    ST_GSTART,
    ST_GPIX,
    ST_GWR,
    ST_READ,
    ST_DONE
  } state_t;

  localparam logic [7:0] DIGIT_GLYPHS [10][5] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
    '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46},
    '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
    '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30},
    '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E}
  };

  // P R O X I M T Y
  localparam logic [7:0] LETTER_GLYPHS [8][5] = '{
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
    '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F},
    '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}
  };

  function automatic logic glyph_exists(input logic [7:0] code);
    logic hit;
    hit = 1'b0;
    case (code) inside
      "P", "R", "O", "X", "I", "M", "T", "Y", [8'h30:8'h39]: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
    logic [7:0] g;
    logic [7:0] d;
    g = 8'h00;
    d = code - CODE_ZERO;
    if (col <= 3'd4) begin
      case (code)
        "P": g = LETTER_GLYPHS[0][col];
        "R": g = LETTER_GLYPHS[1][col];
        "O": g = LETTER_GLYPHS[2][col];
        "X": g = LETTER_GLYPHS[3][col];
        "I": g = LETTER_GLYPHS[4][col];
        "M": g = LETTER_GLYPHS[5][col];
        "T": g = LETTER_GLYPHS[6][col];
        "Y": g = LETTER_GLYPHS[7][col];
        default: if (d <= 8'd9) g = DIGIT_GLYPHS[d[3:0]][col];
      endcase
    end
    return g;
  endfunction

  function automatic logic [7:0] label_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = "P";
      4'd1: c = "R";
      4'd2: c = "O";
      4'd3: c = "X";
      4'd4: c = "I";
      4'd5: c = "M";
      4'd6: c = "I";
      4'd7: c = "T";
      default: c = "Y";
    endcase
    return c;
  endfunction

endpackage

@@ design/fbt_channels.sv @@
// request and response channel interfaces
interface fbt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  char_code;
  logic [7:0]  x_pos;
  logic [7:0]  y_pos;
  logic [3:0]  scale_factor;
  logic [11:0] value;
  logic [9:0]  byte_index;

  modport source (output valid, action, char_code, x_pos, y_pos, scale_factor, value,
                  byte_index, input ready);
  modport sink   (input valid, action, char_code, x_pos, y_pos, scale_factor, value,
                  byte_index, output ready);
endinterface

interface fbt_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       glyph_found;

  modport source (output valid, read_data, glyph_found, input ready);
  modport sink   (input valid, read_data, glyph_found, output ready);
endinterface

@@ design/fbt_ram.sv @@
// generic ram, one write port, one registered read port
module fbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ design/framebuffer_text_renderer_core.sv @@
// clear: sweeps the store, one byte a cycle
// draw_value: double dabble of the value, the clearing sweep, then the label and value glyphs
// draw_char: steps through the glyph pixels; each set pixel is read, then written back
// read_byte: the byte is read from the store and returned; one word is taken at a time
// reset: a clearing pass of the whole store runs after rst, no word is taken meanwhile
// rst is synchronous, active high
`include "framebuffer_text_renderer_core_macros.svh"

module framebuffer_text_renderer_core #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input logic       clk,
  input logic       rst,
  fbt_req_if.sink   req,
  fbt_rsp_if.source rsp
);

  localparam int PAGES = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = DISPLAY_WIDTH * PAGES;
  localparam int AW = $clog2(STORE_BYTES);

  fbt_pkg::state_t state, state_next;

  logic          init;
  logic [1:0]    act;
  logic          text_mode;
  logic [AW-1:0] clr_addr;
  logic          in_range;
  logic [7:0]    res_data;
  logic          res_found;
  logic          rsp_valid;
  logic [7:0]    rsp_data;
  logic          rsp_found;

  logic [11:0]   dd_bin;
  logic [15:0]   bcd;
  logic [3:0]    dd_cnt;
  logic [3:0]    txt_idx;
  logic [7:0]    pen;

  logic [7:0]    code;
  logic [7:0]    base_x;
  logic [7:0]    base_y;
  logic [3:0]    scale;
  logic [2:0]    col;
  logic [2:0]    row;
  logic [3:0]    dx;
  logic [3:0]    dy;
  logic [7:0]    colx;
  logic [7:0]    rowy;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_mask;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  fbt_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic accept;
  assign accept = req.valid && req.ready;

  // pixel address and glyph bit
  logic [7:0]  px;
  logic [7:0]  py;
  logic        on_screen;
  logic [13:0] lin;
  logic [AW-1:0] pix_addr;
  logic [7:0]  gcol;
  logic        gbit;
  logic        pix_write;

  assign px = colx + 8'(dx);
  assign py = rowy + 8'(dy);
  assign on_screen = ({1'b0, px} < 9'(DISPLAY_WIDTH)) && ({1'b0, py} < 9'(DISPLAY_HEIGHT));
  assign lin = 14'(py[7:3]) * 14'(DISPLAY_WIDTH) + 14'(px);
  assign pix_addr = lin[AW-1:0];
  assign gcol = fbt_pkg::glyph_col(code, col);
  assign gbit = gcol[row];
  assign pix_write = gbit && on_screen;

  // step through dy, dx, row, col; an unset bit skips its whole block
  logic       skip;
  logic [2:0] col_n;
  logic [2:0] row_n;
  logic [3:0] dx_n;
  logic [3:0] dy_n;
  logic [7:0] colx_n;
  logic [7:0] rowy_n;
  logic       step_last;

  assign skip = (state == fbt_pkg::ST_GPIX) && !gbit;

  always_comb begin
    col_n = col;
    row_n = row;
    dx_n = dx;
    dy_n = dy;
    colx_n = colx;
    rowy_n = rowy;
    step_last = 1'b0;
    if (!skip && (dy != scale - 4'd1)) begin
      dy_n = dy + 4'd1;
    end else if (!skip && (dx != scale - 4'd1)) begin
      dy_n = 4'd0;
      dx_n = dx + 4'd1;
    end else begin
      dy_n = 4'd0;
      dx_n = 4'd0;
      if (row != 3'd6) begin
        row_n = row + 3'd1;
        rowy_n = rowy + 8'(scale);
      end else begin
        row_n = 3'd0;
        rowy_n = base_y;
        if (col != 3'd4) begin
          col_n = col + 3'd1;
          colx_n = colx + 8'(scale);
        end else begin
          step_last = 1'b1;
        end
      end
    end
  end

  // decimal digits of the value
  logic [15:0] bcd_adj;
  logic [2:0]  n_digits;
  logic [5:0]  text_w;
  logic [7:0]  value_x;
  logic [3:0]  txt_end;
  logic [3:0]  dig_j;
  logic [1:0]  dig_pos;
  logic [3:0]  dig_nib;
  logic [7:0]  txt_code;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_comb begin
    if (bcd[15:12] != 4'd0) n_digits = 3'd4;
    else if (bcd[11:8] != 4'd0) n_digits = 3'd3;
    else if (bcd[7:4] != 4'd0) n_digits = 3'd2;
    else n_digits = 3'd1;
  end

  assign text_w = 6'(n_digits) * fbt_pkg::DIGIT_W;
  assign value_x = ({3'b0, text_w} < 9'(DISPLAY_WIDTH))
                   ? 8'((9'(DISPLAY_WIDTH) - {3'b0, text_w}) >> 1) : 8'd0;
  assign txt_end = fbt_pkg::LABEL_LEN + 4'(n_digits);
  assign dig_j = txt_idx - fbt_pkg::LABEL_LEN;
  assign dig_pos = 2'(4'(n_digits) - 4'd1 - dig_j);
  assign dig_nib = bcd[{dig_pos, 2'b00} +: 4];
  assign txt_code = (txt_idx < fbt_pkg::LABEL_LEN) ? fbt_pkg::label_char(txt_idx)
                                                   : fbt_pkg::CODE_ZERO + 8'(dig_nib);

  logic gstart_empty;
  logic clr_last;
  logic rsp_free;

  assign gstart_empty = !fbt_pkg::glyph_exists(code) || (scale == 4'd0);
  assign clr_last = (clr_addr == AW'(STORE_BYTES - 1));
  assign rsp_free = !rsp_valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fbt_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req.action)
            fbt_pkg::ACT_CLEAR:      state_next = fbt_pkg::ST_CLEAR;
            fbt_pkg::ACT_DRAW_CHAR:  state_next = fbt_pkg::ST_GSTART;
            fbt_pkg::ACT_DRAW_VALUE: state_next = fbt_pkg::ST_DABBLE;
            default:                 state_next = fbt_pkg::ST_READ;
          endcase
        end
      end
      fbt_pkg::ST_CLEAR: begin
        if (clr_last) begin
          if (init) state_next = fbt_pkg::ST_IDLE;
          else if (act == fbt_pkg::ACT_DRAW_VALUE) state_next = fbt_pkg::ST_TEXT;
          else state_next = fbt_pkg::ST_DONE;
        end
      end
      fbt_pkg::ST_DABBLE: if (dd_cnt == 4'd11) state_next = fbt_pkg::ST_CLEAR;
      fbt_pkg::ST_TEXT: begin
        state_next = (txt_idx == txt_end) ? fbt_pkg::ST_DONE : fbt_pkg::ST_GSTART;
      end
      fbt_pkg::ST_GSTART: begin
        if (gstart_empty) state_next = text_mode ? fbt_pkg::ST_TEXT : fbt_pkg::ST_DONE;
        else state_next = fbt_pkg::ST_GPIX;
      end
      fbt_pkg::ST_GPIX: begin
        if (pix_write) state_next = fbt_pkg::ST_GWR;
        else if (step_last) state_next = text_mode ? fbt_pkg::ST_TEXT : fbt_pkg::ST_DONE;
      end
      fbt_pkg::ST_GWR: begin
        if (step_last) state_next = text_mode ? fbt_pkg::ST_TEXT : fbt_pkg::ST_DONE;
        else state_next = fbt_pkg::ST_GPIX;
      end
      fbt_pkg::ST_READ: state_next = fbt_pkg::ST_DONE;
      fbt_pkg::ST_DONE: if (rsp_free) state_next = fbt_pkg::ST_IDLE;
      default: state_next = fbt_pkg::ST_IDLE;
    endcase
  end

  // store access and handshake outputs
  always_comb begin
    req.ready = (state == fbt_pkg::ST_IDLE);
    ram_we = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = 8'h00;
    ram_raddr = pix_addr;
    unique case (state)
      fbt_pkg::ST_IDLE: ram_raddr = AW'(req.byte_index);
      fbt_pkg::ST_CLEAR: ram_we = 1'b1;
      fbt_pkg::ST_GWR: begin
        ram_we = 1'b1;
        ram_waddr = wr_addr;
        ram_wdata = ram_rdata | wr_mask;
      end
      default: ;
    endcase
  end

  assign rsp.valid = rsp_valid;
  assign rsp.read_data = rsp_data;
  assign rsp.glyph_found = rsp_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbt_pkg::ST_CLEAR;
      init <= 1'b1;
      clr_addr <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == fbt_pkg::ST_DONE) && rsp_free) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;

      unique case (state)
        fbt_pkg::ST_IDLE: begin
          if (accept) begin
            act <= req.action;
            clr_addr <= '0;
            res_data <= 8'h00;
            res_found <= (req.action == fbt_pkg::ACT_DRAW_CHAR)
                         && fbt_pkg::glyph_exists(req.char_code);
            in_range <= (32'(req.byte_index) < 32'(STORE_BYTES));
            code <= req.char_code;
            base_x <= req.x_pos;
            base_y <= req.y_pos;
            scale <= req.scale_factor;
            text_mode <= (req.action == fbt_pkg::ACT_DRAW_VALUE);
            dd_bin <= req.value;
            bcd <= 16'h0000;
            dd_cnt <= 4'd0;
            txt_idx <= 4'd0;
            pen <= fbt_pkg::LABEL_X;
          end
        end
        fbt_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_last) init <= 1'b0;
        end
        fbt_pkg::ST_DABBLE: begin
          bcd <= {bcd_adj[14:0], dd_bin[11]};
          dd_bin <= {dd_bin[10:0], 1'b0};
          dd_cnt <= dd_cnt + 4'd1;
        end
        fbt_pkg::ST_TEXT: begin
          code <= txt_code;
          base_x <= pen;
          if (txt_idx < fbt_pkg::LABEL_LEN) begin
            base_y <= fbt_pkg::LABEL_Y;
            scale <= 4'd1;
          end else begin
            base_y <= fbt_pkg::VALUE_Y;
            scale <= 4'd2;
          end
        end
        fbt_pkg::ST_GSTART: begin
          col <= 3'd0;
          row <= 3'd0;
          dx <= 4'd0;
          dy <= 4'd0;
          colx <= base_x;
          rowy <= base_y;
        end
        fbt_pkg::ST_GPIX: begin
          wr_addr <= pix_addr;
          wr_mask <= 8'h01 << py[2:0];
          if (!pix_write) begin
            col <= col_n;
            row <= row_n;
            dx <= dx_n;
            dy <= dy_n;
            colx <= colx_n;
            rowy <= rowy_n;
          end
        end
        fbt_pkg::ST_GWR: begin
          col <= col_n;
          row <= row_n;
          dx <= dx_n;
          dy <= dy_n;
          colx <= colx_n;
          rowy <= rowy_n;
        end
        fbt_pkg::ST_READ: res_data <= in_range ? ram_rdata : 8'h00;
        fbt_pkg::ST_DONE: begin
          if (rsp_free) begin
            rsp_data <= res_data;
            rsp_found <= res_found;
          end
        end
        default: ;
      endcase

      // next character of the label or value text
      if (text_mode && (state_next == fbt_pkg::ST_TEXT) && (state != fbt_pkg::ST_CLEAR)) begin
        txt_idx <= txt_idx + 4'd1;
        if (txt_idx == fbt_pkg::LABEL_LEN - 4'd1) pen <= value_x;
        else pen <= pen + 8'(scale) * fbt_pkg::PITCH;
      end
    end
  end

  `FBT_ASSERT_NXT(a_accept_leaves_idle, accept, state != fbt_pkg::ST_IDLE, "word taken but idle")
  `FBT_ASSERT_IMP(a_write_source, ram_we, (state == fbt_pkg::ST_CLEAR) || (state == fbt_pkg::ST_GWR), "stray store write")
  `FBT_ASSERT_IMP(a_write_after_read, state == fbt_pkg::ST_GWR, $past(state) == fbt_pkg::ST_GPIX, "pixel write without read")

endmodule

@@ verif/fbt_frame_checker.sv @@
// checker for the text renderer core: frame store prediction and response comparison
module fbt_frame_checker (
  input  logic clk,
  input  logic rst,
  fbt_req_if   req,
  fbt_rsp_if   rsp,
  output int   fails,
  output int   outstanding
);

  localparam int W = 128;
  localparam int H = 64;
  localparam int BYTES = W * ((H + 7) / 8);

  typedef struct packed {
    logic [7:0] read_data;
    logic       glyph_found;
  } reply_t;

  localparam logic [7:0] NUM_FONT [10][5] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E}
  };
  localparam logic [7:0] ALPHA_FONT [8][5] = '{
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F},
    '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01}, '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}
  };
  localparam logic [7:0] ALPHA_CODES [8] = '{"P", "R", "O", "X", "I", "M", "T", "Y"};
  localparam logic [7:0] LABEL_TEXT [9] = '{"P", "R", "O", "X", "I", "M", "I", "T", "Y"};

  logic [7:0] frame [BYTES];
  reply_t     replies_due [$];

  function automatic void set_pixel(int x, int y);
    if (x < W && y < H) frame[(y / 8) * W + x] |= 8'(1 << (y % 8));
  endfunction

  function automatic bit paint_glyph(int x, int y, logic [7:0] code, int sc);
    logic [7:0] cols [5];
    bit         hit;
    hit = 1'b0;
    for (int i = 0; i < 8; i++)
      if (code == ALPHA_CODES[i] && !hit) begin
        cols = ALPHA_FONT[i];
        hit = 1'b1;
      end
    if (!hit && code >= "0" && code <= "9") begin
      cols = NUM_FONT[code - "0"];
      hit = 1'b1;
    end
    if (!hit) return 1'b0;
    for (int c = 0; c < 5; c++)
      for (int r = 0; r < 7; r++)
        if (cols[c][r])
          for (int dx = 0; dx < sc; dx++)
            for (int dy = 0; dy < sc; dy++)
              set_pixel((x + c * sc + dx) & 255, (y + r * sc + dy) & 255);
    return 1'b1;
  endfunction

  function automatic void paint_reading(logic [11:0] v);
    logic [7:0] txt [4];
    int         n, x, v_left;
    foreach (frame[i]) frame[i] = '0;
    x = 37;
    for (int i = 0; i < 9; i++) begin
      void'(paint_glyph(x, 5, LABEL_TEXT[i], 1));
      x = (x + 6) & 255;
    end
    v_left = v;
    n = (v >= 1000) ? 4 : (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
    for (int i = n - 1; i >= 0; i--) begin
      txt[i] = 8'("0" + v_left % 10);
      v_left = v_left / 10;
    end
    x = (W - n * 12) / 2;
    for (int i = 0; i < n; i++) begin
      void'(paint_glyph(x, 28, txt[i], 2));
      x = (x + 12) & 255;
    end
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  initial begin
    fails = 0;
    foreach (frame[i]) frame[i] = '0;
  end

  assign outstanding = replies_due.size();

  always @(posedge clk) begin
    reply_t want, got;
    if (rst) begin
      foreach (frame[i]) frame[i] = '0;
      replies_due.delete();
    end else begin
      if (req.valid && req.ready) begin
        want = '0;
        case (req.action)
          fbt_pkg::ACT_CLEAR:      foreach (frame[i]) frame[i] = '0;
          fbt_pkg::ACT_DRAW_CHAR:  want.glyph_found = paint_glyph(req.x_pos, req.y_pos,
                                                                  req.char_code,
                                                                  req.scale_factor);
          fbt_pkg::ACT_DRAW_VALUE: paint_reading(req.value);
          default:                 want.read_data = (req.byte_index < BYTES) ?
                                                    frame[req.byte_index] : 8'h00;
        endcase
        replies_due.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.read_data, rsp.glyph_found};
        if (replies_due.size() == 0) begin
          report("unexpected response word", got.read_data, 8'h00);
        end else begin
          want = replies_due.pop_front();
          if (got.read_data !== want.read_data)
            report("read_data", got.read_data, want.read_data);
          if (got.glyph_found !== want.glyph_found)
            report("glyph_found", 8'(got.glyph_found), 8'(want.glyph_found));
        end
      end
    end
  end
endmodule

@@ verif/tb_framebuffer_text_renderer_core.sv @@
// testbench top: stimulus, idling and verdict for the text renderer core
module tb_framebuffer_text_renderer_core;

  logic clk;
  logic rst;
  int   fails;
  int   outstanding;
  bit   gaps_on;
  int   last_x, last_y;

  fbt_req_if req ();
  fbt_rsp_if rsp ();

  framebuffer_text_renderer_core u_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  fbt_frame_checker u_chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                           .fails(fails), .outstanding(outstanding));

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #80000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send(logic [1:0] act, logic [7:0] code, logic [7:0] x, logic [7:0] y,
                      logic [3:0] sc, logic [11:0] v, logic [9:0] idx);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req.valid = 1'b1;
    req.action = act;
    req.char_code = code;
    req.x_pos = x;
    req.y_pos = y;
    req.scale_factor = sc;
    req.value = v;
    req.byte_index = idx;
    while (!req.ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    int         pick, sc;
    logic [7:0] code;
    logic [9:0] idx;
    logic [7:0] glyph_set [18] = '{"P", "R", "O", "X", "I", "M", "T", "Y", "0", "1", "2",
                                   "3", "4", "5", "6", "7", "8", "9"};
    pick = $urandom_range(0, 99);
    sc = ($urandom_range(0, 29) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 4);
    code = ($urandom_range(0, 4) == 0) ? 8'($urandom) : glyph_set[$urandom_range(0, 17)];
    idx = ($urandom_range(0, 1) == 0) ?
          10'((last_y / 8 % 8) * 128 + (last_x + $urandom_range(0, 15)) % 128) : 10'($urandom);
    if (pick < 3)
      send(fbt_pkg::ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
           12'($urandom), 10'($urandom));
    else if (pick < 8)
      send(fbt_pkg::ACT_DRAW_VALUE, 8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
           12'($urandom), 10'($urandom));
    else if (pick < 48) begin
      last_x = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 127);
      last_y = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 63);
      send(fbt_pkg::ACT_DRAW_CHAR, code, 8'(last_x), 8'(last_y), 4'(sc), 12'($urandom),
           10'($urandom));
    end else
      send(fbt_pkg::ACT_READ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
           12'($urandom), idx);
  endtask

  initial begin
    int busy;
    rsp.ready = 1'b0;
    busy = 0;
    forever begin
      @(negedge clk);
      if (busy > 0) begin
        busy--;
        rsp.ready = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        busy = $urandom_range(1, 7) - 1;
        rsp.ready = 1'b0;
      end else
        rsp.ready = 1'b1;
    end
  end

  initial begin
    int         waited;
    logic [7:0] directed_codes [8] = '{"P", "Y", "M", "0", "9", "5", 8'h00, 8'hFF};
    rst = 1'b1;
    gaps_on = 1'b1;
    last_x = 0;
    last_y = 0;
    req.valid = 1'b0;
    req.action = fbt_pkg::ACT_CLEAR;
    req.char_code = '0;
    req.x_pos = '0;
    req.y_pos = '0;
    req.scale_factor = '0;
    req.value = '0;
    req.byte_index = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    send(fbt_pkg::ACT_READ_BYTE, 8'hFF, 8'hFF, 8'hFF, 4'hF, 12'hFFF, 10'd0);
    send(fbt_pkg::ACT_READ_BYTE, 8'h00, 8'h00, 8'h00, 4'h0, 12'h000, 10'd1023);
    foreach (directed_codes[i])
      send(fbt_pkg::ACT_DRAW_CHAR, directed_codes[i], 8'(i * 14), 8'(i * 7), 4'd1, 12'h0,
           10'h0);
    send(fbt_pkg::ACT_DRAW_CHAR, "8", 8'd10, 8'd10, 4'd0, 12'h0, 10'h0);
    send(fbt_pkg::ACT_DRAW_CHAR, "X", 8'd250, 8'd252, 4'd15, 12'h0, 10'h0);
    send(fbt_pkg::ACT_DRAW_CHAR, "R", 8'd120, 8'd60, 4'd3, 12'h0, 10'h0);
    send(fbt_pkg::ACT_READ_BYTE, 8'h0, 8'h0, 8'h0, 4'h0, 12'h0, 10'd0);
    send(fbt_pkg::ACT_READ_BYTE, 8'h0, 8'h0, 8'h0, 4'h0, 12'h0, 10'd127);
    send(fbt_pkg::ACT_DRAW_VALUE, 8'h0, 8'h0, 8'h0, 4'h0, 12'd4095, 10'h0);
    send(fbt_pkg::ACT_READ_BYTE, 8'h0, 8'h0, 8'h0, 4'h0, 12'h0, 10'd421);
    send(fbt_pkg::ACT_DRAW_VALUE, 8'h0, 8'h0, 8'h0, 4'h0, 12'd0, 10'h0);
    send(fbt_pkg::ACT_READ_BYTE, 8'h0, 8'h0, 8'h0, 4'h0, 12'h0, 10'd443);
    send(fbt_pkg::ACT_DRAW_VALUE, 8'h0, 8'h0, 8'h0, 4'h0, 12'd99, 10'h0);
    send(fbt_pkg::ACT_READ_BYTE, 8'h0, 8'h0, 8'h0, 4'h0, 12'h0, 10'd180);
    send(fbt_pkg::ACT_CLEAR, 8'h0, 8'h0, 8'h0, 4'h0, 12'h0, 10'h0);
    send(fbt_pkg::ACT_READ_BYTE, 8'h0, 8'h0, 8'h0, 4'h0, 12'h0, 10'd180);

    for (int i = 0; i < 1100; i++) begin
      if (i == 900) gaps_on = 1'b0;
      send_random();
    end
    req.valid = 1'b0;

    waited = 0;
    while (outstanding != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (50) @(negedge clk);
    if (fails == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+design
design/fbt_pkg.sv
design/fbt_channels.sv
design/fbt_ram.sv
design/framebuffer_text_renderer_core.sv
verif/fbt_frame_checker.sv
verif/tb_framebuffer_text_renderer_core.sv
